// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the converter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/i2da_pkg.sv =====
// ----------------------------------------------------------------------------
// i2da_pkg
// Word types and fixed widths for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2da_pkg;

   localparam int VALUE_W   = 31;
   localparam int COUNT_W   = 4;
   localparam int START_W   = 16;
   localparam int CHAR_W    = 6;
   localparam int POS_W     = 17;
   localparam int BIT_CNT_W = 5;

   // ASCII code of '0'; digits follow it in order
   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
   localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

   // Double dabble correction: a digit of five or more gets three added
   localparam logic [3:0] DD_THRESHOLD = 4'd5;
   localparam logic [3:0] DD_BIAS      = 4'd3;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] digit_count;
      logic [START_W-1:0] start_position;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic [POS_W-1:0]  write_position;
      logic              last;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/integer_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii
// Bit-serial binary to decimal ASCII converter, one digit word per strobe.
// ----------------------------------------------------------------------------
//  Channel   Ports                      Direction  Transfer
//  request   start, busy, req_word      in         start high while busy low
//  response  rsp_strobe, rsp_word       out        one strobe per digit word
//
//  Conversion shifts the value in one bit a cycle through a double dabble
//  register. Emission then visits one digit position a cycle: n for a
//  fixed count n, MAX_DIGITS for natural width (leading zeros are
//  stepped over silently). No new request is taken while busy is high.
//  Synchronous reset clears control; busy drops with the last digit word.
//  The receiver cannot stall; every word is taken in its strobe cycle.
`default_nettype none
`include "assert_macros.svh"

module integer_to_decimal_ascii #(
   parameter int MAX_DIGITS = 10
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire i2da_pkg::req_type  req_word,
   output logic                    rsp_strobe,
   output i2da_pkg::rsp_type       rsp_word
);

   localparam int BCD_W = 4 * MAX_DIGITS;
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   state_type                          state_ff, state_in;
   logic                               busy_ff, busy_in;
   logic [i2da_pkg::VALUE_W-1:0]       value_ff, value_in;
   logic [i2da_pkg::BIT_CNT_W-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [BCD_W-1:0]                   bcd_ff, bcd_in;
   logic [IDX_W-1:0]                   idx_ff, idx_in;
   logic                               started_ff, started_in;
   logic [i2da_pkg::POS_W-1:0]         pos_ff, pos_in;
   logic                               strobe_ff, strobe_in;
   i2da_pkg::rsp_type                  word_ff, word_in;

   logic [BCD_W-1:0]                   dd_adj;
   logic [3:0]                         cur_digit;
   logic [IDX_W-1:0]                   first_idx;
   logic                               accept;
   logic                               emit;

   assign accept = start && !busy_ff;

   // Add three to every digit of five or more ahead of the shift
   always_comb begin
      dd_adj = bcd_ff;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= i2da_pkg::DD_THRESHOLD) begin
            dd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + i2da_pkg::DD_BIAS;
         end
      end
   end

   // First digit to visit: count minus one, saturated; natural width scans from the top
   always_comb begin
      if (req_word.digit_count == '0 ||
          32'(req_word.digit_count) > 32'(MAX_DIGITS)) begin
         first_idx = IDX_W'(MAX_DIGITS - 1);
      end else begin
         first_idx = IDX_W'(32'(req_word.digit_count) - 32'd1);
      end
   end

   assign cur_digit = bcd_ff[4*int'(idx_ff) +: 4];
   assign emit      = started_ff || (cur_digit != 4'd0) || (idx_ff == '0);

   // Next state and datapath
   always_comb begin
      state_in   = state_ff;
      busy_in    = busy_ff;
      value_in   = value_ff;
      bit_cnt_in = bit_cnt_ff;
      bcd_in     = bcd_ff;
      idx_in     = idx_ff;
      started_in = started_ff;
      pos_in     = pos_ff;
      strobe_in  = 1'b0;
      word_in    = word_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in   = ST_CONVERT;
               busy_in    = 1'b1;
               value_in   = req_word.value;
               bit_cnt_in = i2da_pkg::BIT_CNT_W'(i2da_pkg::VALUE_W - 1);
               bcd_in     = '0;
               idx_in     = first_idx;
               started_in = (req_word.digit_count != '0);
               pos_in     = {1'b0, req_word.start_position};
            end
         end
         ST_CONVERT: begin
            // Shift one value bit into the decimal register
            bcd_in   = {dd_adj[BCD_W-2:0], value_ff[i2da_pkg::VALUE_W-1]};
            value_in = {value_ff[i2da_pkg::VALUE_W-2:0], 1'b0};
            // A carry off the top digit means the number is wider than the register
            if (dd_adj[BCD_W-1]) begin
               started_in = 1'b1;
            end
            if (bit_cnt_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            if (emit) begin
               strobe_in              = 1'b1;
               started_in             = 1'b1;
               word_in.digit_char     = i2da_pkg::ASCII_ZERO + {2'b00, cur_digit};
               word_in.write_position = pos_ff;
               word_in.last           = (idx_ff == '0);
               pos_in                 = pos_ff + 1'b1;
            end
            if (idx_ff == '0) begin
               state_in = ST_IDLE;
               busy_in  = 1'b0;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      bit_cnt_ff <= bit_cnt_in;
      bcd_ff     <= bcd_in;
      idx_ff     <= idx_in;
      started_ff <= started_in;
      pos_ff     <= pos_in;
      word_ff    <= word_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_word   = word_ff;

   // Checks
   `ASSERT_NEXT(a_accept_loads, clock, reset, accept,
      state_ff == ST_CONVERT && bit_cnt_ff == i2da_pkg::BIT_CNT_W'(i2da_pkg::VALUE_W - 1))
   `ASSERT_IMP(a_digit_range, clock, reset, rsp_strobe,
      rsp_word.digit_char >= i2da_pkg::ASCII_ZERO && rsp_word.digit_char <= i2da_pkg::ASCII_NINE)
   `ASSERT_IMP(a_last_frees, clock, reset, rsp_strobe, rsp_word.last == !busy)

endmodule

`default_nettype wire

// ===== dv/i2da_digit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2da_digit_checker
// Watches the request and response channels of the decimal ASCII converter.
// Each accepted request word is expanded into the digit words it must give.
// Every strobed response word is compared with the oldest of them.
// The count of mismatches and of digits still awaited go to the top.
// ----------------------------------------------------------------------------
module i2da_digit_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              busy,
   input  wire i2da_pkg::req_type req_word,
   input  wire logic              rsp_strobe,
   input  wire i2da_pkg::rsp_type rsp_word,
   output int                     mismatch_count,
   output int                     digits_pending
);

   localparam int MAX_DIGITS = 10;

   i2da_pkg::rsp_type expected_digits[$];

   // Expand one number into its digit words, most significant first
   function automatic void queue_digits(input i2da_pkg::req_type w);
      int unsigned       width;
      int unsigned       i;
      longint unsigned   rest;
      longint unsigned   scale;
      longint unsigned   digit;
      i2da_pkg::rsp_type d;
      width = w.digit_count;
      if (width == 0) begin
         // natural width: count the places of the value
         width = 1;
         rest  = w.value;
         while (rest > 9) begin
            rest = rest / 10;
            width++;
         end
      end
      // saturate oversized counts
      if (width > MAX_DIGITS) width = MAX_DIGITS;
      scale = 1;
      for (i = 1; i < width; i++) scale = scale * 10;
      for (i = 0; i < width; i++) begin
         digit            = (longint'(w.value) / scale) % 10;
         d.digit_char     = i2da_pkg::CHAR_W'(i2da_pkg::ASCII_ZERO + digit);
         d.write_position = i2da_pkg::POS_W'(w.start_position + i);
         d.last           = (i + 1 == width);
         expected_digits.push_back(d);
         scale = scale / 10;
      end
   endfunction

   // Record accepted requests, then check any strobed digit word
   always @(posedge clock) begin
      i2da_pkg::rsp_type want;
      if (!reset) begin
         if (start && !busy) queue_digits(req_word);
         if (rsp_strobe) begin
            if (expected_digits.size() == 0) begin
               $display("%0t: unexpected digit word: char %0d pos %0d last %0b",
                        $time, rsp_word.digit_char, rsp_word.write_position,
                        rsp_word.last);
               mismatch_count++;
            end else begin
               want = expected_digits.pop_front();
               if (rsp_word.digit_char !== want.digit_char ||
                   rsp_word.write_position !== want.write_position ||
                   rsp_word.last !== want.last) begin
                  $display("%0t: digit word mismatch: expected char %0d pos %0d last %0b,",
                           $time, want.digit_char, want.write_position, want.last);
                  $display("%0t:   actual char %0d pos %0d last %0b",
                           $time, rsp_word.digit_char, rsp_word.write_position,
                           rsp_word.last);
                  mismatch_count++;
               end
            end
         end
      end
      digits_pending = expected_digits.size();
   end

endmodule

// ===== dv/tb_integer_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_decimal_ascii
// Stimulus and verdict for the integer to decimal ASCII converter.
// A directed set covers zero, the widest values, padding, truncation,
// saturated counts and position wrap-past; random numbers follow in
// phases with and without idle cycles on the request side. Checking is
// left to the digit checker placed beside the block.
// ----------------------------------------------------------------------------
module tb_integer_to_decimal_ascii;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 80;
   localparam int PHASE_ITEMS  = 85;

   logic              clock;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   i2da_pkg::req_type req_word = '0;
   logic              busy;
   logic              rsp_strobe;
   i2da_pkg::rsp_type rsp_word;
   int                mismatch_count;
   int                digits_pending;
   int                cycle_count = 0;
   int                idle_pct[4] = '{0, 69, 0, 6};

   integer_to_decimal_ascii dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   i2da_digit_checker digit_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_word       (req_word),
      .rsp_strobe     (rsp_strobe),
      .rsp_word       (rsp_word),
      .mismatch_count (mismatch_count),
      .digits_pending (digits_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("integer_to_decimal_ascii test failed");
         $finish;
      end
   end

   function automatic i2da_pkg::req_type number_word(
         input logic [i2da_pkg::VALUE_W-1:0] v,
         input logic [i2da_pkg::COUNT_W-1:0] c,
         input logic [i2da_pkg::START_W-1:0] p);
      i2da_pkg::req_type w;
      w.value          = v;
      w.digit_count    = c;
      w.start_position = p;
      return w;
   endfunction

   // Random number: spread over digit widths, edges and positions near wrap
   function automatic i2da_pkg::req_type random_number();
      i2da_pkg::req_type w;
      int unsigned       kind;
      int unsigned       places;
      longint unsigned   ceiling;
      kind = $urandom_range(9);
      if (kind < 4) begin
         w.value = i2da_pkg::VALUE_W'($urandom);
      end else if (kind < 8) begin
         places  = $urandom_range(1, 10);
         ceiling = 1;
         repeat (places) ceiling = ceiling * 10;
         if (ceiling > 64'h8000_0000) ceiling = 64'h8000_0000;
         w.value = i2da_pkg::VALUE_W'(longint'($urandom) % ceiling);
      end else if (kind == 8) begin
         w.value = i2da_pkg::VALUE_W'($urandom_range(20));
      end else begin
         // power of ten, one either side
         places  = $urandom_range(1, 9);
         ceiling = 1;
         repeat (places) ceiling = ceiling * 10;
         w.value = i2da_pkg::VALUE_W'(ceiling + $urandom_range(2) - 1);
      end
      w.digit_count = ($urandom_range(9) < 4) ? '0 :
                      i2da_pkg::COUNT_W'($urandom_range(1, 15));
      if ($urandom_range(3) == 0)
         w.start_position = i2da_pkg::START_W'(16'hFFFF - $urandom_range(12));
      else w.start_position = i2da_pkg::START_W'($urandom);
      return w;
   endfunction

   // Present a word and hold it until the block takes it
   task automatic send_word(input i2da_pkg::req_type w);
      start    <= 1'b1;
      req_word <= w;
      // busy here is what the next rising edge sees
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   // Drop start for a random stretch, with noise on the request word
   task automatic idle_gap(input int pct);
      if (pct != 0 && $urandom_range(99) < pct) begin
         start <= 1'b0;
         do begin
            req_word <= random_number();
            @(negedge clock);
         end while ($urandom_range(99) < pct);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero, natural width and padded
      send_word(number_word(31'd0, 4'd0, 16'd0));
      send_word(number_word(31'd0, 4'd1, 16'd1));
      send_word(number_word(31'd0, 4'd10, 16'd2));
      send_word(number_word(31'd5, 4'd0, 16'd100));
      // width steps at powers of ten
      send_word(number_word(31'd9, 4'd0, 16'd7));
      send_word(number_word(31'd10, 4'd0, 16'd8));
      send_word(number_word(31'd99, 4'd0, 16'd9));
      send_word(number_word(31'd100, 4'd0, 16'd10));
      send_word(number_word(31'd999999999, 4'd0, 16'd11));
      send_word(number_word(31'd1000000000, 4'd0, 16'd12));
      // widest value and position wrap-past
      send_word(number_word(31'h7FFF_FFFF, 4'd0, 16'hFFFF));
      send_word(number_word(31'h7FFF_FFFF, 4'd10, 16'hFFFA));
      // truncation to the low digits, and padding
      send_word(number_word(31'h7FFF_FFFF, 4'd1, 16'd3));
      send_word(number_word(31'h7FFF_FFFF, 4'd3, 16'd4));
      send_word(number_word(31'd123, 4'd5, 16'd5));
      // counts above the limit saturate; full-width zero padding at wrap
      send_word(number_word(31'd7, 4'd11, 16'd6));
      send_word(number_word(31'd7, 4'd15, 16'h8000));
      send_word(number_word(31'd1234567890, 4'd12, 16'h7FFF));
      send_word(number_word(31'd0, 4'd10, 16'hFFFF));
      // alternating bit patterns
      send_word(number_word(31'h2AAA_AAAA, 4'd0, 16'hAAAA));
      send_word(number_word(31'h5555_5555, 4'd0, 16'h5555));
      send_word(number_word(31'h5555_5555, 4'd9, 16'hFFFE));

      // random phases: steady, sparse, steady, lightly gapped
      foreach (idle_pct[ph]) begin
         repeat (PHASE_ITEMS) begin
            idle_gap(idle_pct[ph]);
            send_word(random_number());
         end
      end
      start <= 1'b0;

      // drain, then let the block settle
      while (digits_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && digits_pending == 0) begin
         $display("integer_to_decimal_ascii test passed");
      end else begin
         if (digits_pending != 0)
            $display("%0t: %0d expected digit words never arrived", $time, digits_pending);
         $display("integer_to_decimal_ascii test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/i2da_pkg.sv
sv/integer_to_decimal_ascii.sv
dv/i2da_digit_checker.sv
dv/tb_integer_to_decimal_ascii.sv
